### hw/rtl/linear_frame_resampler_assert.svh
// Assertion macros shared by the resampler's checker.
// Both sample on the rising clock edge and are disabled while rst_n is low.
`ifndef LINEAR_FRAME_RESAMPLER_ASSERT_SVH
`define LINEAR_FRAME_RESAMPLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lfr_pkg.sv
package lfr_pkg;

  // Fixed field and register widths.
  localparam int DATA_W      = 32;  // in_sample and out_sample on the ports
  localparam int IC_W        = 21;  // in_count register
  localparam int OC_W        = 23;  // out_count register
  localparam int CFG_W       = 23;  // widest register
  localparam int CNT_W       = 25;  // common width for index comparisons
  localparam int DIV_W       = 24;  // divisor width (twice the largest out_count - 1)
  localparam int REM_W       = 25;  // divider partial remainder
  localparam int POS_SUM_W   = 24;  // remainder plus span before the position divide
  localparam int MUL_STEPS   = 23;  // one step per bit of the interpolation weights
  localparam int POS_STEPS   = 24;  // one step per bit of the position dividend
  localparam int MAX_RESULTS = 5;   // results per input item at most
  localparam int N_W         = 3;   // counter of results per input item

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_IN_COUNT  = 1'b0,
    REG_OUT_COUNT = 1'b1
  } cfg_reg_t;

  // Source of a result loaded into the output register.
  typedef enum logic [1:0] {
    SRC_ERR    = 2'd0,
    SRC_X      = 2'd1,
    SRC_INTERP = 2'd2
  } out_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHECK,
    ST_SETUP,
    ST_MUL,
    ST_NLOAD,
    ST_DIV,
    ST_SAVE,
    ST_POS,
    ST_POS_UPD,
    ST_EMIT_INTERP,
    ST_EMIT_FINAL,
    ST_EMIT_COPY,
    ST_EMIT_ERR,
    ST_FINISH
  } lfr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     setup;
    logic     mul_step;
    logic     nload;
    logic     div_step;
    logic     save;
    logic     pos_upd;
    logic     idx_inc;
    logic     out_load;
    out_src_t out_src;
    logic     out_last;
    logic     advance;
    logic     err_advance;
  } lfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cfg_ok;
    logic d_zero;
    logic j_zero;
    logic loop_ok;
    logic final_ok;
    logic out_free;
  } lfr_stat_t;

endpackage

### hw/rtl/linear_frame_resampler.sv
// Linear frame resampler. Signed samples arrive one per input request in
// frames of in_count samples, and out_count samples leave per frame; the first
// and last outputs coincide with the first and last inputs, and each output in
// between is the linear interpolation of its two neighbouring inputs, computed
// exactly and rounded half away from zero. An output leaves once its right
// neighbour has arrived, so one input gives up to five results, the last of
// them marked by tlast; the first input of a frame gives none unless
// out_count is 1, when it is copied. A configuration that needs more than
// UP_RATIO outputs per input interval is flagged: every input then gives one
// zero result with ratio_error set. Writing either register restarts the
// frame; write only while the block is idle. One item is processed at a time.
// Each interpolated result needs 23 steps of the shift-add multiplier and then
// the shared one-bit-per-cycle divider, SAMPLE_BITS steps for the rounded
// quotient and 24 steps to advance the source position. No memory needs
// clearing after reset.
module linear_frame_resampler import lfr_pkg::*; #(
  parameter int MAX_SPAN    = 1048576,
  parameter int UP_RATIO    = 4,
  parameter int SAMPLE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration write port.
  input  logic              cfg_wr_en,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  // Input samples.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] in_sample
  // Resampled output.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [31:0] out_sample
  output logic              out_tlast,  // run_last
  output logic [1:0]        out_tuser   // [0] frame_end, [1] ratio_error
);

  lfr_cmd_t  cmd;
  lfr_stat_t stat;

  lfr_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lfr_dp #(
    .MAX_SPAN    (MAX_SPAN),
    .UP_RATIO    (UP_RATIO),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### hw/rtl/lfr_div.sv
// Restoring divider, one quotient bit per step. The dividend bits wait
// left-aligned in the quotient register and are shifted into the remainder.
module lfr_div import lfr_pkg::*; #(
  parameter int QW = 32
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [REM_W-1:0] init_rem,
  input  logic [QW-1:0]    init_quo,
  input  logic [DIV_W-1:0] divisor,
  output logic [QW-1:0]    quo,
  output logic [REM_W-1:0] rem
);

  logic [REM_W-1:0] rem_r;
  logic [QW-1:0]    quo_r;
  logic [DIV_W-1:0] div_r;
  logic [REM_W-1:0] rem_sh;
  logic             ge;

  // Bring down the next dividend bit and try the subtraction.
  assign rem_sh = {rem_r[REM_W-2:0], quo_r[QW-1]};
  assign ge     = rem_sh >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= init_rem;
      quo_r <= init_quo;
      div_r <= divisor;
    end else if (step) begin
      rem_r <= ge ? (rem_sh - {1'b0, div_r}) : rem_sh;
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

### hw/rtl/lfr_dp.sv
// Datapath: configuration, frame counters, serial multiplier, shared divider
// and the output register.
module lfr_dp import lfr_pkg::*; #(
  parameter int MAX_SPAN    = 1048576,
  parameter int UP_RATIO    = 4,
  parameter int SAMPLE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic              out_tready,
  input  lfr_cmd_t          cmd,
  output lfr_stat_t         stat,
  output logic              out_tvalid,
  output logic [DATA_W-1:0] out_tdata,
  output logic              out_tlast,
  output logic [1:0]        out_tuser
);

  localparam int SB    = SAMPLE_BITS;
  localparam int IDX_W = $clog2(MAX_SPAN);
  localparam int ACC_W = SB + OC_W + 1;
  localparam int QW    = (SB > POS_SUM_W) ? SB : POS_SUM_W;
  localparam int LIM_W = IC_W + $clog2(UP_RATIO + 1) + 1;

  logic [IC_W-1:0]      in_count_r;
  logic [OC_W-1:0]      out_count_r;
  logic signed [SB-1:0] prev_r;
  logic signed [SB-1:0] x_r;
  logic [IDX_W-1:0]     in_index_r;
  logic [OC_W-1:0]      out_index_r;
  logic [IDX_W-1:0]     pos_left_r;
  logic [OC_W-1:0]      pos_rem_r;
  logic [SB:0]          sum_ab_r;
  logic [OC_W-1:0]      dr_r;
  logic [OC_W-1:0]      rr_r;
  logic [ACC_W-1:0]     acc_r;
  logic                 neg_r;
  logic                 fend_r;
  logic signed [SB-1:0] samp_r;
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_data_r;
  logic                 out_last_r;
  logic                 out_fend_r;
  logic                 out_err_r;

  logic [IC_W-1:0]      span;
  logic [OC_W-1:0]      d;
  logic [LIM_W-1:0]     lim;
  logic                 err_fend;
  logic                 err_wrap;
  logic                 frame_done;
  logic [SB:0]          sel;
  logic [ACC_W-1:0]     acc2;
  logic [ACC_W-1:0]     n_val;
  logic [POS_SUM_W-1:0] pos_sum;
  logic                 div_load;
  logic [REM_W-1:0]     div_init_rem;
  logic [QW-1:0]        div_init_quo;
  logic [DIV_W-1:0]     div_divisor;
  logic [QW-1:0]        div_quo;
  logic [REM_W-1:0]     div_rem;
  logic [SB-1:0]        q_mag;

  assign span = in_count_r - IC_W'(1);
  assign d    = out_count_r - OC_W'(1);

  // Supported configuration and the position tests on the frame counters.
  assign lim = LIM_W'(UP_RATIO) * (LIM_W'(in_count_r) - LIM_W'(1)) + LIM_W'(1);
  assign stat.cfg_ok = (in_count_r >= IC_W'(2)) &&
                       (CNT_W'(in_count_r) <= CNT_W'(MAX_SPAN)) &&
                       (out_count_r != '0) && (LIM_W'(out_count_r) <= lim);
  assign stat.d_zero   = (out_count_r == OC_W'(1));
  assign stat.j_zero   = (in_index_r == '0);
  assign stat.loop_ok  = (in_index_r != '0) && (out_index_r <= d) &&
                         ((IDX_W + 1)'(pos_left_r) + (IDX_W + 1)'(1) ==
                          (IDX_W + 1)'(in_index_r));
  assign stat.final_ok = (CNT_W'(in_index_r) == CNT_W'(span)) && (out_index_r == d) &&
                         (CNT_W'(pos_left_r) == CNT_W'(span)) && (pos_rem_r == '0);
  assign stat.out_free = !out_valid_r || out_tready;

  assign err_fend   = (CNT_W'(in_index_r) + CNT_W'(1)) >= CNT_W'(in_count_r);
  assign err_wrap   = err_fend || ((CNT_W'(in_index_r) + CNT_W'(1)) >= CNT_W'(MAX_SPAN));
  assign frame_done = CNT_W'(in_index_r) >= CNT_W'(span);

  // Weight bit pair selects the addend of the shift-add multiplier.
  always_comb begin
    case ({dr_r[OC_W-1], rr_r[OC_W-1]})
      2'b10:   sel = {prev_r[SB-1], prev_r};
      2'b01:   sel = {x_r[SB-1], x_r};
      2'b11:   sel = sum_ab_r;
      default: sel = '0;
    endcase
  end

  // Rounded dividend 2*|num| + d, formed with a single add or subtract.
  assign acc2  = {acc_r[ACC_W-2:0], 1'b0};
  assign n_val = acc_r[ACC_W-1] ? (ACC_W'(d) - acc2) : (acc2 + ACC_W'(d));
  assign pos_sum = POS_SUM_W'(pos_rem_r) + POS_SUM_W'(span);

  // The divider is loaded either for the sample quotient or the position step.
  assign div_load = cmd.nload || cmd.save;
  always_comb begin
    if (cmd.save) begin
      div_init_rem = '0;
      div_init_quo = QW'(pos_sum) << (QW - POS_SUM_W);
      div_divisor  = DIV_W'(d);
    end else begin
      div_init_rem = REM_W'(n_val >> SB);
      div_init_quo = QW'(n_val[SB-1:0]) << (QW - SB);
      div_divisor  = {d, 1'b0};
    end
  end

  lfr_div #(.QW(QW)) u_div (
    .clk      (clk),
    .load     (div_load),
    .step     (cmd.div_step),
    .init_rem (div_init_rem),
    .init_quo (div_init_quo),
    .divisor  (div_divisor),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign q_mag = div_quo[SB-1:0];

  // Configuration and frame state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_count_r  <= IC_W'(2);
      out_count_r <= OC_W'(2);
      prev_r      <= '0;
      in_index_r  <= '0;
      out_index_r <= '0;
      pos_left_r  <= '0;
      pos_rem_r   <= '0;
    end else begin
      if (cmd.idx_inc) begin
        out_index_r <= out_index_r + OC_W'(1);
      end
      if (cmd.pos_upd) begin
        pos_left_r <= IDX_W'(CNT_W'(pos_left_r) + CNT_W'(div_quo[POS_SUM_W-1:0]));
        pos_rem_r  <= div_rem[OC_W-1:0];
      end
      if (cmd.advance) begin
        prev_r <= x_r;
        if (frame_done) begin
          in_index_r  <= '0;
          out_index_r <= '0;
          pos_left_r  <= '0;
          pos_rem_r   <= '0;
        end else begin
          in_index_r <= in_index_r + IDX_W'(1);
        end
      end
      if (cmd.err_advance) begin
        prev_r      <= x_r;
        in_index_r  <= err_wrap ? '0 : (in_index_r + IDX_W'(1));
        out_index_r <= '0;
        pos_left_r  <= '0;
        pos_rem_r   <= '0;
      end
      // A register write starts a new frame with the next input.
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_IN_COUNT:  in_count_r  <= cfg_data[IC_W-1:0];
          REG_OUT_COUNT: out_count_r <= cfg_data[OC_W-1:0];
          default:       out_count_r <= out_count_r;
        endcase
        in_index_r  <= '0;
        out_index_r <= '0;
        pos_left_r  <= '0;
        pos_rem_r   <= '0;
      end
    end
  end

  // Input capture, multiplier and interpolation result.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r <= SB'(in_tdata);
    end
    if (cmd.setup) begin
      sum_ab_r <= {prev_r[SB-1], prev_r} + {x_r[SB-1], x_r};
      dr_r     <= d - pos_rem_r;
      rr_r     <= pos_rem_r;
      acc_r    <= '0;
      fend_r   <= (out_index_r == d);
    end
    if (cmd.mul_step) begin
      acc_r <= acc2 + {{(ACC_W - SB - 1){sel[SB]}}, sel};
      dr_r  <= {dr_r[OC_W-2:0], 1'b0};
      rr_r  <= {rr_r[OC_W-2:0], 1'b0};
    end
    if (cmd.nload) begin
      neg_r <= acc_r[ACC_W-1];
    end
    if (cmd.save) begin
      samp_r <= neg_r ? SB'(~q_mag + SB'(1)) : q_mag;
    end
  end

  // Output register: holds one result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last_r <= cmd.out_last;
      case (cmd.out_src)
        SRC_X: begin
          out_data_r <= DATA_W'(x_r);
          out_fend_r <= 1'b1;
          out_err_r  <= 1'b0;
        end
        SRC_INTERP: begin
          out_data_r <= DATA_W'(samp_r);
          out_fend_r <= fend_r;
          out_err_r  <= 1'b0;
        end
        default: begin
          out_data_r <= '0;
          out_fend_r <= err_fend;
          out_err_r  <= 1'b1;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_err_r, out_fend_r};

endmodule

### hw/rtl/lfr_ctrl.sv
// Controller: sequences one input item through its results.
module lfr_ctrl import lfr_pkg::*; #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  lfr_stat_t stat,
  output lfr_cmd_t  cmd
);

  localparam int QW     = (SAMPLE_BITS > POS_SUM_W) ? SAMPLE_BITS : POS_SUM_W;
  localparam int STEP_W = $clog2(QW);

  lfr_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [N_W-1:0]    n_r, n_nxt;
  logic              room;
  logic              more;

  // Another result may follow while fewer than the maximum have been given.
  assign room = n_r < N_W'(MAX_RESULTS);
  assign more = (N_W'(n_r + N_W'(1)) < N_W'(MAX_RESULTS)) && (stat.loop_ok || stat.final_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      // The input stays closed while reset is held.
      ST_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load_in = 1'b1;
          n_nxt       = '0;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!stat.cfg_ok) begin
          state_nxt = ST_EMIT_ERR;
        end else if (stat.d_zero) begin
          state_nxt = stat.j_zero ? ST_EMIT_COPY : ST_FINISH;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      // Next interpolated output, the frame's closing output, or done.
      ST_CHECK: begin
        if (room && stat.loop_ok) begin
          state_nxt = ST_SETUP;
        end else if (room && stat.final_ok) begin
          state_nxt = ST_EMIT_FINAL;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        cnt_nxt   = STEP_W'(MUL_STEPS - 1);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_NLOAD;
        end else begin
          cnt_nxt = cnt_r - STEP_W'(1);
        end
      end
      ST_NLOAD: begin
        cmd.nload = 1'b1;
        cnt_nxt   = STEP_W'(SAMPLE_BITS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_SAVE;
        end else begin
          cnt_nxt = cnt_r - STEP_W'(1);
        end
      end
      ST_SAVE: begin
        cmd.save    = 1'b1;
        cmd.idx_inc = 1'b1;
        cnt_nxt     = STEP_W'(POS_STEPS - 1);
        state_nxt   = ST_POS;
      end
      ST_POS: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_POS_UPD;
        end else begin
          cnt_nxt = cnt_r - STEP_W'(1);
        end
      end
      ST_POS_UPD: begin
        cmd.pos_upd = 1'b1;
        state_nxt   = ST_EMIT_INTERP;
      end
      ST_EMIT_INTERP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_INTERP;
          cmd.out_last = !more;
          n_nxt        = n_r + N_W'(1);
          state_nxt    = ST_CHECK;
        end
      end
      ST_EMIT_FINAL: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_X;
          cmd.out_last = 1'b1;
          cmd.idx_inc  = 1'b1;
          state_nxt    = ST_FINISH;
        end
      end
      ST_EMIT_COPY: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_X;
          cmd.out_last = 1'b1;
          state_nxt    = ST_FINISH;
        end
      end
      ST_EMIT_ERR: begin
        if (stat.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_src     = SRC_ERR;
          cmd.out_last    = 1'b1;
          cmd.err_advance = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_FINISH: begin
        cmd.advance = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/lfr_checker.sv
`include "linear_frame_resampler_assert.svh"

// Port-level checks on the resampler.
module lfr_checker import lfr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic              out_tlast,
  input logic [1:0]        out_tuser
);

  // A pending result stays offered until it is taken.
  `LFR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result withdrawn")

  // Items are taken one at a time, so an accepted request closes the input.
  `LFR_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "input reopened early")

  // A flagged result is a lone zero.
  `LFR_ASSERT_SAME(a_err_shape, out_tvalid && out_tuser[1], out_tlast && (out_tdata == '0), "bad error result")

  // The closing output of a frame is always the last result of its input.
  `LFR_ASSERT_SAME(a_fend_last, out_tvalid && out_tuser[0], out_tlast, "frame end not last")

endmodule

bind linear_frame_resampler lfr_checker u_lfr_checker (.*);
